// ===== hdl/bsfb_pkg.sv =====
// Package for the byte-stuffed frame builder.
// Holds widths, register indexes, the sequencer step type and the job records.
// No dependencies.
package bsfb_pkg;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Frame length limit and counter ceiling
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OVF_LIMIT       = MAX_FRAME_BYTES - 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Stuffing mask applied after an escape byte
    localparam logic [BYTE_W-1:0] STUFF_MASK = 8'h20;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] FLAG_RESET = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_RESET  = 8'h7D;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h03;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ESC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADDR = 2'd2;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] escape_value;
        logic [BYTE_W-1:0] address_value;
    } t_cfg;

    // One accepted input item
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              first_of_frame;
        logic              last_of_frame;
        logic [BYTE_W-1:0] control_value;
    } t_item;

    // Classified item: everything the back end needs to emit its bytes
    typedef struct packed {
        logic [BYTE_W-1:0] control_value;
        logic [BYTE_W-1:0] data_out;     // payload byte, already masked if stuffed
        logic [BYTE_W-1:0] check_out;    // check byte, already masked if stuffed
        logic              first;
        logic              last;
        logic              stuff_data;
        logic              stuff_check;
        logic              overflow;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Emission steps of one job
    typedef enum logic [3:0] {
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_BCC,
        ST_DESC,
        ST_DATA,
        ST_CESC,
        ST_CHK,
        ST_CLOSE
    } t_step;

endpackage

// ===== hdl/bsfb_in_if.sv =====
// Input channel of the frame builder: valid/ready plus one payload item.
// No dependencies.
interface bsfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [7:0] control_value;

    modport source (
        output valid, payload_byte, first_of_frame, last_of_frame, control_value,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, first_of_frame, last_of_frame, control_value,
        output ready
    );
endinterface

// ===== hdl/bsfb_out_if.sv =====
// Output channel of the frame builder: valid/ready plus one line byte result.
// No dependencies.
interface bsfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;
    logic       frame_overflow;

    modport source (
        output valid, line_byte, run_last, frame_done, frame_overflow,
        input  ready
    );
    modport sink (
        input  valid, line_byte, run_last, frame_done, frame_overflow,
        output ready
    );
endinterface

// ===== hdl/bsfb_front.sv =====
// Front end: accepts items, keeps check/count/overflow state, builds jobs.
// Depends on bsfb_pkg.
module bsfb_front import bsfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_item     i_item,
    input  t_q_status i_q_status,
    output logic      o_ready,
    output logic      o_push,
    output t_job      o_job
);

    logic [BYTE_W-1:0]  r_check;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic [BYTE_W-1:0]  n_check;
    logic [COUNT_W-1:0] n_count;
    logic               n_ovf;

    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] count_data;
    logic [COUNT_W:0]   sum_data;
    logic [COUNT_W:0]   sum_tail;
    logic [2:0]         inc_data;
    logic [1:0]         inc_tail;
    logic               stuff_d;
    logic               stuff_c;
    logic               ovf_now;

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // Classify payload and check bytes, advance frame state
    always_comb begin
        base_count = i_item.first_of_frame ? '0 : r_count;
        n_check    = (i_item.first_of_frame ? '0 : r_check) ^ i_item.payload_byte;

        stuff_d = (i_item.payload_byte == i_cfg.flag_value) ||
                  (i_item.payload_byte == i_cfg.escape_value);
        stuff_c = (n_check == i_cfg.flag_value) || (n_check == i_cfg.escape_value);

        // header plus payload byte(s), saturating
        inc_data   = (i_item.first_of_frame ? 3'd4 : 3'd0) + (stuff_d ? 3'd2 : 3'd1);
        sum_data   = {1'b0, base_count} + (COUNT_W+1)'(inc_data);
        count_data = sum_data[COUNT_W] ? COUNT_MAX : sum_data[COUNT_W-1:0];

        ovf_now = (!i_item.first_of_frame && r_ovf) ||
                  (32'(count_data) >= 32'(OVF_LIMIT)) || (count_data == COUNT_MAX);

        // check byte(s) and closing flag
        inc_tail = stuff_c ? 2'd3 : 2'd2;
        sum_tail = {1'b0, count_data} + (COUNT_W+1)'(inc_tail);
        if (i_item.last_of_frame) begin
            n_count = sum_tail[COUNT_W] ? COUNT_MAX : sum_tail[COUNT_W-1:0];
        end else begin
            n_count = count_data;
        end
        n_ovf = ovf_now;

        o_job.control_value = i_item.control_value;
        o_job.data_out      = stuff_d ? (i_item.payload_byte ^ STUFF_MASK)
                                      : i_item.payload_byte;
        o_job.check_out     = stuff_c ? (n_check ^ STUFF_MASK) : n_check;
        o_job.first         = i_item.first_of_frame;
        o_job.last          = i_item.last_of_frame;
        o_job.stuff_data    = stuff_d;
        o_job.stuff_check   = stuff_c;
        o_job.overflow      = ovf_now;
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (o_push) begin
            r_check <= n_check;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== hdl/bsfb_queue.sv =====
// Short job queue between front and back ends.
// Depends on bsfb_pkg.
module bsfb_queue import bsfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/bsfb_back.sv =====
// Back end: steps through the bytes of the head job, one per cycle while the
// output is not stalled, into an output register. Depends on bsfb_pkg.
module bsfb_back import bsfb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_job              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_line_byte,
    output logic              o_run_last,
    output logic              o_frame_done,
    output logic              o_frame_overflow
);

    t_step             r_step;
    t_step             n_step;
    logic              r_mid;
    logic              n_mid;
    t_step             cur_step;
    logic              advance;
    logic              job_end;
    logic [BYTE_W-1:0] step_byte;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_done;
    logic              r_ovf;

    assign advance = !i_q_status.empty && (!r_valid || i_out_ready);
    assign o_pop   = advance && job_end;

    // Current step: first step of a fresh job, else the stored one
    always_comb begin
        if (r_mid) begin
            cur_step = r_step;
        end else if (i_head.first) begin
            cur_step = ST_FLAG;
        end else if (i_head.stuff_data) begin
            cur_step = ST_DESC;
        end else begin
            cur_step = ST_DATA;
        end
    end

    // Next-state logic
    always_comb begin
        n_step = r_step;
        n_mid  = r_mid;
        if (advance) begin
            n_mid = !job_end;
            case (cur_step)
                ST_FLAG:  n_step = ST_ADDR;
                ST_ADDR:  n_step = ST_CTRL;
                ST_CTRL:  n_step = ST_BCC;
                ST_BCC:   n_step = i_head.stuff_data ? ST_DESC : ST_DATA;
                ST_DESC:  n_step = ST_DATA;
                ST_DATA:  n_step = i_head.stuff_check ? ST_CESC : ST_CHK;
                ST_CESC:  n_step = ST_CHK;
                ST_CHK:   n_step = ST_CLOSE;
                ST_CLOSE: n_step = ST_FLAG;
                default:  n_step = ST_FLAG;
            endcase
        end
    end

    // Output logic: byte of the current step and end-of-job marker
    always_comb begin
        job_end = 1'b0;
        case (cur_step)
            ST_FLAG:  step_byte = i_cfg.flag_value;
            ST_ADDR:  step_byte = i_cfg.address_value;
            ST_CTRL:  step_byte = i_head.control_value;
            ST_BCC:   step_byte = i_cfg.address_value ^ i_head.control_value;
            ST_DESC:  step_byte = i_cfg.escape_value;
            ST_DATA: begin
                step_byte = i_head.data_out;
                job_end   = !i_head.last;
            end
            ST_CESC:  step_byte = i_cfg.escape_value;
            ST_CHK:   step_byte = i_head.check_out;
            ST_CLOSE: begin
                step_byte = i_cfg.flag_value;
                job_end   = 1'b1;
            end
            default:  step_byte = i_cfg.flag_value;
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_FLAG;
            r_mid  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_mid  <= n_mid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= step_byte;
            r_last <= job_end;
            r_done <= (cur_step == ST_CLOSE);
            r_ovf  <= i_head.overflow;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_line_byte      = r_byte;
    assign o_run_last       = r_last;
    assign o_frame_done     = r_done;
    assign o_frame_overflow = r_ovf;

endmodule

// ===== hdl/byte_stuffed_frame_builder_core.sv =====
// Top level of the byte-stuffed frame builder: configuration registers, front end, job
// queue and back end. Depends on bsfb_pkg, both channel interfaces, the submodules.
//
//  Channel   Role    Carries
//  i_in      sink    payload_byte, first_of_frame, last_of_frame, control_value
//  o_out     source  line_byte, run_last, frame_done, frame_overflow
//  i_cfg_*   write   flag (0), escape (1), address (2); 8-bit data
//
// One item is taken per cycle while the 4-entry job queue has room.
// Each item produces 1 to 9 line bytes, one per cycle from the back-end sequencer
// while the output is not stalled. The first result passes through the job queue
// and the back-end output register. Reset is synchronous; it clears queue, sequencer
// and frame state and loads the configuration registers with their reset values.
// A stalled output holds its register; the front keeps taking items until the
// queue fills.
module byte_stuffed_frame_builder_core import bsfb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsfb_in_if.sink               i_in,
    bsfb_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_item     in_item;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic      in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value    <= FLAG_RESET;
            r_cfg.escape_value  <= ESC_RESET;
            r_cfg.address_value <= ADDR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_FLAG: r_cfg.flag_value    <= i_cfg_data;
                CFG_IDX_ESC:  r_cfg.escape_value  <= i_cfg_data;
                CFG_IDX_ADDR: r_cfg.address_value <= i_cfg_data;
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    // Gather the input payload
    assign in_item.payload_byte   = i_in.payload_byte;
    assign in_item.first_of_frame = i_in.first_of_frame;
    assign in_item.last_of_frame  = i_in.last_of_frame;
    assign in_item.control_value  = i_in.control_value;
    assign i_in.ready             = in_ready;

    bsfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_in.valid),
        .i_item     (in_item),
        .i_q_status (q_status),
        .o_ready    (in_ready),
        .o_push     (push),
        .o_job      (push_job)
    );

    bsfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    bsfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head           (head_job),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_line_byte      (o_out.line_byte),
        .o_run_last       (o_out.run_last),
        .o_frame_done     (o_out.frame_done),
        .o_frame_overflow (o_out.frame_overflow)
    );

endmodule

// ===== hdl/bsfb_checker.sv =====
// Port-level checks for the frame builder, bound to the top level.
// No package dependency.
module bsfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_line_byte,
    input logic       i_run_last,
    input logic       i_frame_done,
    input logic       i_frame_overflow
);

    // No result is offered in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The closing flag always ends the run of its item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_frame_done) |-> i_run_last)
        else $error("frame_done without run_last");

    // A stalled result stays offered and unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_line_byte) && $stable(i_run_last) &&
             $stable(i_frame_done) && $stable(i_frame_overflow)))
        else $error("stalled result changed");

endmodule

bind byte_stuffed_frame_builder_core bsfb_checker u_bsfb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_line_byte      (o_out.line_byte),
    .i_run_last       (o_out.run_last),
    .i_frame_done     (o_out.frame_done),
    .i_frame_overflow (o_out.frame_overflow)
);

// ===== dv/byte_stuffed_frame_builder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_stuffed_frame_builder_core: directed and random frames,
// several register settings and idling modes.
// Depends on bsfb_pkg, bsfb_in_if, bsfb_out_if and the core itself.
module byte_stuffed_frame_builder_core_tb;
    import bsfb_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up

    // One line byte as the core should emit it
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              run_last;
        logic              frame_done;
        logic              frame_overflow;
    } line_res_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bsfb_in_if  in_ch ();
    bsfb_out_if out_ch ();

    byte_stuffed_frame_builder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Register copies and frame state of the predictor
    logic [BYTE_W-1:0]  cfg_flag = FLAG_RESET;
    logic [BYTE_W-1:0]  cfg_esc  = ESC_RESET;
    logic [BYTE_W-1:0]  cfg_addr = ADDR_RESET;
    logic [BYTE_W-1:0]  frame_check;
    logic [COUNT_W-1:0] frame_len;
    logic               frame_ovf;

    // Line bytes of the item being encoded
    logic [BYTE_W-1:0]  enc_byte [9];
    logic               enc_done [9];
    int                 enc_n;

    t_item     payload_items [$];
    line_res_t pending_line_bytes [$];

    // Driver / monitor bookkeeping
    t_item cur_item;
    logic  in_held = 1'b0;
    logic  in_took = 1'b0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    stall_cycles = 0;
    int    fail_cnt = 0;
    int    items_in = 0;
    int    lines_checked = 0;
    int    frames_closed = 0;
    int    ovf_results = 0;
    int    settings_used = 1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_item mk_item(logic [7:0] data, logic first, logic last,
                                      logic [7:0] ctrl);
        t_item it;
        it.payload_byte   = data;
        it.first_of_frame = first;
        it.last_of_frame  = last;
        it.control_value  = ctrl;
        return it;
    endfunction

    // Append one line byte; the frame length saturates at the counter ceiling
    function automatic void emit_line(logic [7:0] b, logic done);
        if (enc_n < 9) begin
            enc_byte[enc_n] = b;
            enc_done[enc_n] = done;
            enc_n++;
        end
        if (frame_len < COUNT_MAX)
            frame_len++;
    endfunction

    function automatic void emit_stuffed(logic [7:0] b);
        if (b == cfg_flag || b == cfg_esc) begin
            emit_line(cfg_esc, 1'b0);
            emit_line(b ^ STUFF_MASK, 1'b0);
        end else begin
            emit_line(b, 1'b0);
        end
    endfunction

    // Work out the line bytes one accepted payload item causes
    function automatic void encode_item(t_item it);
        line_res_t r;
        enc_n = 0;
        if (it.first_of_frame) begin
            frame_check = '0;
            frame_len   = '0;
            frame_ovf   = 1'b0;
            emit_line(cfg_flag, 1'b0);
            emit_line(cfg_addr, 1'b0);
            emit_line(it.control_value, 1'b0);
            emit_line(cfg_addr ^ it.control_value, 1'b0);
        end
        emit_stuffed(it.payload_byte);
        frame_check ^= it.payload_byte;
        // overflow is judged once the payload byte is out, before the trailer
        if (frame_len >= OVF_LIMIT || frame_len >= COUNT_MAX)
            frame_ovf = 1'b1;
        if (it.last_of_frame) begin
            emit_stuffed(frame_check);
            emit_line(cfg_flag, 1'b1);
        end
        for (int k = 0; k < enc_n; k++) begin
            r.line_byte      = enc_byte[k];
            r.run_last       = (k == enc_n - 1);
            r.frame_done     = enc_done[k];
            r.frame_overflow = frame_ovf;
            pending_line_bytes.push_back(r);
        end
    endfunction

    // Payload bytes biased toward the ones that get stuffed
    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return cfg_flag;
        else if (r < 35)
            return cfg_esc;
        else if (r < 40)
            return cfg_flag ^ STUFF_MASK;
        return 8'($urandom);
    endfunction

    // Mostly well-formed frames with random content, some loose items
    task automatic queue_frames(input int count);
        int         queued;
        int         len;
        logic [7:0] ctrl;
        logic [7:0] acc;
        logic [7:0] data;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(99) < 12) begin
                payload_items.push_back(mk_item(pick_payload(), 1'($urandom_range(1)),
                                                1'($urandom_range(1)), 8'($urandom)));
                queued++;
            end else begin
                len  = ($urandom_range(3) == 0) ? 1 : $urandom_range(10, 2);
                ctrl = 8'($urandom);
                acc  = '0;
                for (int k = 0; k < len; k++) begin
                    data = pick_payload();
                    // steer the check byte onto flag or escape now and then
                    if (k == len - 1 && k > 0 && $urandom_range(2) == 0)
                        data = acc ^ (($urandom_range(1) == 1) ? cfg_flag : cfg_esc);
                    acc ^= data;
                    payload_items.push_back(mk_item(data, k == 0, k == len - 1,
                                                    (k == 0) ? ctrl : 8'($urandom)));
                    queued++;
                end
            end
        end
    endtask

    // Wait until every item is taken and every line byte has come out
    task automatic drain();
        while (payload_items.size() != 0 || in_held || pending_line_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // Write all three registers; only called while the core is idle
    task automatic write_regs(input logic [7:0] flag, input logic [7:0] esc,
                              input logic [7:0] addr);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_FLAG;
        i_cfg_data <= flag;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IDX_ESC;
        i_cfg_data <= esc;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IDX_ADDR;
        i_cfg_data <= addr;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_flag = flag;
        cfg_esc  = esc;
        cfg_addr = addr;
        settings_used++;
    endtask

    // Input driver and output ready, both on the falling edge
    always @(negedge i_clk) begin
        if (in_held && in_took)
            in_held = 1'b0;
        if (!in_held && payload_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item = payload_items.pop_front();
            in_held  = 1'b1;
            in_ch.payload_byte   <= cur_item.payload_byte;
            in_ch.first_of_frame <= cur_item.first_of_frame;
            in_ch.last_of_frame  <= cur_item.last_of_frame;
            in_ch.control_value  <= cur_item.control_value;
        end
        in_ch.valid  <= in_held;
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check output transfers first, then predict from input transfers
    always @(posedge i_clk) begin
        line_res_t want;
        in_took <= in_ch.valid && in_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_line_bytes.size() == 0) begin
                $error("unexpected line byte %02h", out_ch.line_byte);
                fail_cnt++;
            end else begin
                want = pending_line_bytes.pop_front();
                lines_checked++;
                if (want.frame_done)
                    frames_closed++;
                if (want.frame_overflow)
                    ovf_results++;
                if (out_ch.line_byte !== want.line_byte) begin
                    $error("line_byte: expected %02h, got %02h", want.line_byte,
                           out_ch.line_byte);
                    fail_cnt++;
                end
                if (out_ch.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
                    fail_cnt++;
                end
                if (out_ch.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done,
                           out_ch.frame_done);
                    fail_cnt++;
                end
                if (out_ch.frame_overflow !== want.frame_overflow) begin
                    $error("frame_overflow: expected %0b, got %0b", want.frame_overflow,
                           out_ch.frame_overflow);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            encode_item(mk_item(in_ch.payload_byte, in_ch.first_of_frame,
                                in_ch.last_of_frame, in_ch.control_value));
            items_in++;
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_IDX_FLAG;
        i_cfg_data           = '0;
        in_ch.valid          = 1'b0;
        in_ch.payload_byte   = '0;
        in_ch.first_of_frame = 1'b0;
        in_ch.last_of_frame  = 1'b0;
        in_ch.control_value  = '0;
        out_ch.ready         = 1'b0;
        frame_check          = '0;
        frame_len            = '0;
        frame_ovf            = 1'b0;
        enc_n                = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values, no idling
        payload_items.push_back(mk_item(8'h55, 1'b0, 1'b0, 8'h00)); // no frame open yet
        payload_items.push_back(mk_item(8'h7E, 1'b0, 1'b1, 8'h00)); // close it anyway
        payload_items.push_back(mk_item(8'h7E, 1'b1, 1'b1, 8'h00)); // nine line bytes
        payload_items.push_back(mk_item(8'h00, 1'b1, 1'b1, 8'hFF));
        payload_items.push_back(mk_item(8'h7D, 1'b1, 1'b0, 8'h03)); // header check of zero
        payload_items.push_back(mk_item(8'hFF, 1'b0, 1'b0, 8'h00));
        payload_items.push_back(mk_item(8'h20, 1'b0, 1'b0, 8'h00));
        payload_items.push_back(mk_item(8'h5E, 1'b0, 1'b0, 8'h00));
        payload_items.push_back(mk_item(8'h5D, 1'b0, 1'b1, 8'h00));
        payload_items.push_back(mk_item(8'h11, 1'b0, 1'b0, 8'h00)); // after a closed frame
        payload_items.push_back(mk_item(8'h6C, 1'b0, 1'b1, 8'h00));
        payload_items.push_back(mk_item(8'h7C, 1'b1, 1'b0, 8'h80));
        payload_items.push_back(mk_item(8'h01, 1'b0, 1'b1, 8'h00)); // check equals escape
        payload_items.push_back(mk_item(8'h01, 1'b1, 1'b1, 8'h7E)); // control not stuffed
        drain();

        // Directed, register extremes
        write_regs(8'h00, 8'hFF, 8'hFF);
        payload_items.push_back(mk_item(8'h00, 1'b1, 1'b1, 8'h00));
        payload_items.push_back(mk_item(8'hFF, 1'b1, 1'b0, 8'hFF));
        payload_items.push_back(mk_item(8'hFF, 1'b0, 1'b1, 8'h00)); // check of zero
        drain();

        // Random phases over settings and idling modes
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: write_regs(FLAG_RESET, ESC_RESET, ADDR_RESET);
                1: write_regs(8'hFF, 8'h00, 8'h00);
                2: begin
                    cfg_flag = 8'($urandom);
                    write_regs(cfg_flag, cfg_flag, 8'($urandom)); // flag equals escape
                end
                default: write_regs(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            queue_frames(50);
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (pending_line_bytes.size() != 0) begin
            $error("%0d expected line bytes never came out", pending_line_bytes.size());
            fail_cnt++;
        end
        $display("Covered %0d payload transfers and %0d line bytes in %0d closed frames,",
                 items_in, lines_checked, frames_closed);
        $display("over %0d register settings and four idling modes; %0d bytes flagged overflow.",
                 settings_used, ovf_results);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== byte_stuffed_frame_builder_core.f =====
hdl/bsfb_pkg.sv
hdl/bsfb_in_if.sv
hdl/bsfb_out_if.sv
hdl/bsfb_front.sv
hdl/bsfb_queue.sv
hdl/bsfb_back.sv
hdl/byte_stuffed_frame_builder_core.sv
hdl/bsfb_checker.sv
dv/byte_stuffed_frame_builder_core_tb.sv
